/* rtl/hrlp_pkg.sv */
// Shared types, character constants and phase codes for the HTTP request line parser.
// Used by every module under rtl; depends on nothing else.
`timescale 1ns / 1ps
package hrlp_pkg;

    // Hard cap on the URL length; the configured limit is clipped to it.
    localparam int unsigned URL_MAX_BYTES = 4096;
    localparam int unsigned LEN_W         = 12;
    localparam int unsigned LIMIT_W       = LEN_W + 1;
    localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};
    localparam logic [LEN_W-1:0] MAX_URL_LEN_RESET = 12'd255;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [39:0] WORD_GET   = 40'h00_0047_4554;
    localparam logic [39:0] WORD_POST  = 40'h00_504F_5354;
    localparam logic [39:0] WORD_HTTP  = 40'h00_4854_5450;
    localparam logic [39:0] WORD_HTTPS = 40'h48_5454_5053;

    localparam logic [2:0] PH_METHOD   = 3'd0;
    localparam logic [2:0] PH_URL      = 3'd1;
    localparam logic [2:0] PH_PROTO    = 3'd2;
    localparam logic [2:0] PH_VERSION  = 3'd3;
    localparam logic [2:0] PH_HEADERS  = 3'd4;
    localparam logic [2:0] PH_BODY     = 3'd5;
    localparam logic [2:0] PH_FINISHED = 3'd6;
    localparam logic [2:0] PH_ERROR    = 3'd7;

    localparam logic [1:0] METHOD_NONE = 2'd0;
    localparam logic [1:0] METHOD_GET  = 2'd1;
    localparam logic [1:0] METHOD_POST = 2'd2;

    localparam logic [1:0] PROTO_UNKNOWN = 2'd0;
    localparam logic [1:0] PROTO_HTTP    = 2'd1;
    localparam logic [1:0] PROTO_HTTPS   = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_URL  = 2'd1;
    localparam logic [1:0] KIND_BODY = 2'd2;

    typedef enum logic [7:0] {
        PHASE_METHOD   = 8'b0000_0001,
        PHASE_URL      = 8'b0000_0010,
        PHASE_PROTO    = 8'b0000_0100,
        PHASE_VERSION  = 8'b0000_1000,
        PHASE_HEADERS  = 8'b0001_0000,
        PHASE_BODY     = 8'b0010_0000,
        PHASE_FINISHED = 8'b0100_0000,
        PHASE_ERROR    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
        logic       start_of_request;
    } hrlp_in_t;

    typedef struct packed {
        logic [2:0] parse_phase;
        logic [1:0] method_code;
        logic [1:0] proto_code;
        logic [7:0] payload_byte;
        logic [1:0] payload_kind;
        logic       headers_done;
    } hrlp_out_t;

    // A byte after classification, as it waits in the queue.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
        logic       start_of_request;
        logic       is_space;
        logic       is_slash;
        logic       is_cr;
        logic       is_lf;
    } hrlp_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } hrlp_qstat_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PHASE_METHOD:   code = PH_METHOD;
            PHASE_URL:      code = PH_URL;
            PHASE_PROTO:    code = PH_PROTO;
            PHASE_VERSION:  code = PH_VERSION;
            PHASE_HEADERS:  code = PH_HEADERS;
            PHASE_BODY:     code = PH_BODY;
            PHASE_FINISHED: code = PH_FINISHED;
            default:        code = PH_ERROR;
        endcase
        return code;
    endfunction

endpackage

/* rtl/hrlp_front.sv */
// Front end: accepts request bytes and tags the delimiter characters.
// Depends on hrlp_pkg.
`timescale 1ns / 1ps
module hrlp_front import hrlp_pkg::*; (
    input  logic        s_valid,
    output logic        s_ready,
    input  hrlp_in_t    s_data,
    input  hrlp_qstat_t q_stat,
    output logic        wr_en,
    output hrlp_item_t  wr_item
);

    assign s_ready = ~q_stat.full;
    assign wr_en   = s_valid & ~q_stat.full;

    always_comb begin
        wr_item.data_byte        = s_data.data_byte;
        wr_item.end_of_buffer    = s_data.end_of_buffer;
        wr_item.start_of_request = s_data.start_of_request;
        wr_item.is_space         = (s_data.data_byte == CHAR_SPACE);
        wr_item.is_slash         = (s_data.data_byte == CHAR_SLASH);
        wr_item.is_cr            = (s_data.data_byte == CHAR_CR);
        wr_item.is_lf            = (s_data.data_byte == CHAR_LF);
    end

endmodule

/* rtl/hrlp_queue.sv */
// Short queue of classified bytes between the front end and the parse engine.
// Depends on hrlp_pkg.
`timescale 1ns / 1ps
module hrlp_queue import hrlp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        wr_en,
    input  hrlp_item_t  wr_item,
    input  logic        rd_en,
    output hrlp_item_t  rd_item,
    output hrlp_qstat_t q_stat
);

    hrlp_item_t          slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wptr_reg, wptr_next;
    logic [QUEUE_AW-1:0] rptr_reg, rptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    assign q_stat.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_wr        = wr_en & ~q_stat.full;
    assign do_rd        = rd_en & ~q_stat.empty;
    assign rd_item      = slot_reg[rptr_reg];

    always_comb begin
        wptr_next  = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wptr_reg] <= wr_item;
        end
    end

endmodule

/* rtl/hrlp_back.sv */
// Parse engine: steps the phase machine once per queued byte and registers the result.
// Depends on hrlp_pkg.
`timescale 1ns / 1ps
module hrlp_back import hrlp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  hrlp_item_t       rd_item,
    input  hrlp_qstat_t      q_stat,
    output logic             rd_en,
    input  logic [LEN_W-1:0] max_url_len,
    output logic             m_valid,
    input  logic             m_ready,
    output hrlp_out_t        m_data
);

    phase_t           phase_reg, phase_next, phase_cur;
    logic [1:0]       method_reg, method_next, method_cur;
    logic [1:0]       proto_reg, proto_next, proto_cur;
    logic [LEN_W-1:0] tlen_reg, tlen_next, tlen_cur, tlen_sat;
    logic [39:0]      twin_reg, twin_next, twin_cur, twin_push;
    logic             after_cr_reg, after_cr_next, after_cr_cur;
    logic             line_empty_reg, line_empty_next, line_empty_cur;
    logic             out_valid_reg, out_valid_next;
    hrlp_out_t        out_data_reg, out_data_next;
    logic [LIMIT_W-1:0] url_limit;
    logic             fire;
    logic [7:0]       pay;
    logic [1:0]       kind;
    logic             hdone;

    assign fire    = ~q_stat.empty & (~out_valid_reg | m_ready);
    assign rd_en   = fire;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // The smaller of the configured limit and the hard cap.
    assign url_limit = (LIMIT_W'(URL_MAX_BYTES) < {1'b0, max_url_len})
                     ? LIMIT_W'(URL_MAX_BYTES) : {1'b0, max_url_len};

    always_comb begin
        // A start-of-request byte restarts the parse before it is used.
        if (rd_item.start_of_request) begin
            phase_cur      = PHASE_METHOD;
            method_cur     = METHOD_NONE;
            proto_cur      = PROTO_UNKNOWN;
            tlen_cur       = '0;
            twin_cur       = '0;
            after_cr_cur   = 1'b0;
            line_empty_cur = 1'b0;
        end else begin
            phase_cur      = phase_reg;
            method_cur     = method_reg;
            proto_cur      = proto_reg;
            tlen_cur       = tlen_reg;
            twin_cur       = twin_reg;
            after_cr_cur   = after_cr_reg;
            line_empty_cur = line_empty_reg;
        end

        twin_push = {twin_cur[31:0], rd_item.data_byte};
        tlen_sat  = (tlen_cur == LEN_MAX) ? tlen_cur : tlen_cur + 1'b1;

        phase_next      = phase_cur;
        method_next     = method_cur;
        proto_next      = proto_cur;
        tlen_next       = tlen_cur;
        twin_next       = twin_cur;
        after_cr_next   = after_cr_cur;
        line_empty_next = line_empty_cur;
        pay             = 8'h00;
        kind            = KIND_NONE;
        hdone           = 1'b0;

        case (phase_cur)
            PHASE_METHOD: begin
                if (rd_item.is_space) begin
                    if (tlen_cur == LEN_W'(3) && twin_cur == WORD_GET) begin
                        method_next = METHOD_GET;
                        phase_next  = PHASE_URL;
                    end else if (tlen_cur == LEN_W'(4) && twin_cur == WORD_POST) begin
                        method_next = METHOD_POST;
                        phase_next  = PHASE_URL;
                    end else if (method_cur != METHOD_NONE) begin
                        phase_next  = PHASE_URL;
                    end else begin
                        phase_next  = PHASE_ERROR;
                    end
                    tlen_next = '0;
                    twin_next = '0;
                end else begin
                    tlen_next = tlen_sat;
                    twin_next = twin_push;
                end
            end
            PHASE_URL: begin
                if (rd_item.is_space) begin
                    phase_next = PHASE_PROTO;
                    tlen_next  = '0;
                    twin_next  = '0;
                end else if ({1'b0, tlen_cur} >= url_limit) begin
                    phase_next = PHASE_ERROR;
                end else begin
                    tlen_next = tlen_cur + 1'b1;
                    pay       = rd_item.data_byte;
                    kind      = KIND_URL;
                end
            end
            PHASE_PROTO: begin
                if (rd_item.is_slash) begin
                    if (tlen_cur == LEN_W'(4) && twin_cur == WORD_HTTP) begin
                        proto_next = PROTO_HTTP;
                    end else if (tlen_cur == LEN_W'(5) && twin_cur == WORD_HTTPS) begin
                        proto_next = PROTO_HTTPS;
                    end
                    phase_next    = PHASE_VERSION;
                    tlen_next     = '0;
                    twin_next     = '0;
                    after_cr_next = 1'b0;
                end else begin
                    tlen_next = tlen_sat;
                    twin_next = twin_push;
                end
            end
            PHASE_VERSION: begin
                if (rd_item.is_lf && after_cr_cur) begin
                    phase_next      = PHASE_HEADERS;
                    line_empty_next = 1'b1;
                    after_cr_next   = 1'b0;
                end else begin
                    after_cr_next = rd_item.is_cr;
                end
            end
            PHASE_HEADERS: begin
                if (rd_item.is_lf && after_cr_cur) begin
                    after_cr_next = 1'b0;
                    if (line_empty_cur) begin
                        hdone      = 1'b1;
                        phase_next = rd_item.end_of_buffer ? PHASE_FINISHED : PHASE_BODY;
                    end else begin
                        line_empty_next = 1'b1;
                    end
                end else if (rd_item.is_cr) begin
                    // Two CRs in a row: the first was line content.
                    if (after_cr_cur) begin
                        line_empty_next = 1'b0;
                    end
                    after_cr_next = 1'b1;
                end else begin
                    line_empty_next = 1'b0;
                    after_cr_next   = 1'b0;
                end
            end
            PHASE_BODY: begin
                pay  = rd_item.data_byte;
                kind = KIND_BODY;
                if (rd_item.end_of_buffer) begin
                    phase_next = PHASE_FINISHED;
                end
            end
            default: begin
            end
        endcase

        out_data_next.parse_phase  = phase_code(phase_next);
        out_data_next.method_code  = method_next;
        out_data_next.proto_code   = proto_next;
        out_data_next.payload_byte = pay;
        out_data_next.payload_kind = kind;
        out_data_next.headers_done = hdone;

        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PHASE_METHOD;
            method_reg     <= METHOD_NONE;
            proto_reg      <= PROTO_UNKNOWN;
            tlen_reg       <= '0;
            twin_reg       <= '0;
            after_cr_reg   <= 1'b0;
            line_empty_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (fire) begin
                phase_reg      <= phase_next;
                method_reg     <= method_next;
                proto_reg      <= proto_next;
                tlen_reg       <= tlen_next;
                twin_reg       <= twin_next;
                after_cr_reg   <= after_cr_next;
                line_empty_reg <= line_empty_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

/* rtl/http_request_line_parser_core.sv */
// An accepted item is written into the queue when it is taken; the parse engine then pops it,
// and the phase step loads its result into the output register once that register is free.
// The parse engine takes one item per cycle while its output register is free or being taken.
// A four-entry queue lets the input keep taking items while the output stalls, until full.
// Reset (aresetn, synchronous, active low) empties the queue, clears the parse to the
// method phase and sets max_url_len to 255.
`timescale 1ns / 1ps
// Top level of the HTTP request line parser; instantiates hrlp_front, hrlp_queue
// and hrlp_back, and uses hrlp_pkg.
module http_request_line_parser_core import hrlp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [LEN_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  hrlp_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output hrlp_out_t        m_data
);

    // The URL length limit. The user must write it only while the block is idle (the block
    // does not enforce this), so the engine can read it directly without any staging.
    logic [LEN_W-1:0] max_url_len_reg, max_url_len_next;

    hrlp_qstat_t q_stat;
    logic        q_wr_en;
    hrlp_item_t  q_wr_item;
    logic        q_rd_en;
    hrlp_item_t  q_rd_item;

    assign max_url_len_next = cfg_wr_en ? cfg_wr_data : max_url_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_url_len_reg <= MAX_URL_LEN_RESET;
        end else begin
            max_url_len_reg <= max_url_len_next;
        end
    end

    // The front end takes an item whenever the queue has room and marks the
    // space, slash, CR and LF characters that drive the phase machine.
    hrlp_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .wr_en   (q_wr_en),
        .wr_item (q_wr_item)
    );

    // The queue decouples acceptance from result delivery, so a stalled
    // result channel does not immediately stall the input.
    hrlp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_wr_en),
        .wr_item (q_wr_item),
        .rd_en   (q_rd_en),
        .rd_item (q_rd_item),
        .q_stat  (q_stat)
    );

    // The engine pops one item whenever its output register is free or being
    // taken, updates the parse state and registers exactly one result item.
    hrlp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rd_item     (q_rd_item),
        .q_stat      (q_stat),
        .rd_en       (q_rd_en),
        .max_url_len (max_url_len_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
